[design/border_extended_pixel_store_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the border-extended pixel store
// Each macro reports through $error; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef BORDER_EXTENDED_PIXEL_STORE_MACROS_SVH
`define BORDER_EXTENDED_PIXEL_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BEP_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bep assertion failed");

// next-cycle implication
`define BEP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bep assertion failed");

`else

`define BEP_ASSERT_SAME(label, clk, rstn, ante, cons)
`define BEP_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

[design/bep_pkg.sv]
// ----------------------------------------------------------------------------
// bep_pkg
// Types and fixed constants shared by the border-extended pixel store.
// ----------------------------------------------------------------------------
package bep_pkg;

    localparam int SIZE_W    = 9;   // image_width / image_height registers
    localparam int COORD_W   = 10;  // signed col / row
    localparam int IDX_W     = 9;   // remapped in-image coordinate
    localparam int PIXEL_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 40;  // col, row, pixel_in, padded to bytes
    localparam int M_TDATA_W = 16;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BORDER_MODE  = 2'd2;

    typedef enum logic [1:0] {
        BORDER_BLACK   = 2'd0,
        BORDER_CLAMP   = 2'd1,
        BORDER_WRAP    = 2'd2,
        BORDER_REFLECT = 2'd3
    } border_mode_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;      // coordinate after border handling
        logic             outside;  // raw coordinate outside [0, size)
    } coord_map_t;

endpackage

[design/border_extended_pixel_store.sv]
// ----------------------------------------------------------------------------
// border_extended_pixel_store
// Pixel store with border handling (black, clamp, wrap, reflect) on reads.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one transaction per access: s_tuser selects write or read,
//   s_tdata holds col, row and pixel_in. A write inside the active area stores
//   the pixel and returns nothing; a write outside is dropped. Every read
//   returns one m_* transaction with the pixel in m_tdata and the outside flag
//   in m_tuser.
//   cfg_* writes image_width (0), image_height (1) and border_mode (2); only
//   while no access is in flight. Sizes of 0 act as 1, sizes above the maximum
//   act as the maximum.
//   Throughput is one access per cycle while s_tready is high; the single-port
//   pixel memory takes either one write or one read each cycle, in arrival
//   order, so a read sees every earlier write. A read passes the coordinate
//   remap, memory read and output registers before m_tvalid rises.
//   Reset clears the pipeline valids and loads 256 x 256, black border; the
//   pixel memory is not cleared and must be written before it is read.
//   When m_tready is low reads hold in place and writes still complete;
//   s_tready drops once all three stages hold reads.
// ----------------------------------------------------------------------------
`include "border_extended_pixel_store_macros.svh"

module border_extended_pixel_store #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bep_pkg::S_TDATA_W-1:0]     s_tdata,   // col[9:0], row[19:10],
                                                         // pixel_in[35:20], zero pad
    input  logic [0:0]                        s_tuser,   // func[0]
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bep_pkg::M_TDATA_W-1:0]     m_tdata,   // pixel_out[15:0]
    output logic [0:0]                        m_tuser,   // was_outside[0]
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bep_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bep_pkg::SIZE_W-1:0]        cfg_data
);
    import bep_pkg::*;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W  = AW + 10;
    localparam int SIZE_MAX_VAL = (1 << SIZE_W) - 1;
    localparam logic [SIZE_W-1:0] W_LIMIT =
        SIZE_W'((MAX_WIDTH > SIZE_MAX_VAL) ? SIZE_MAX_VAL : MAX_WIDTH);
    localparam logic [SIZE_W-1:0] H_LIMIT =
        SIZE_W'((MAX_HEIGHT > SIZE_MAX_VAL) ? SIZE_MAX_VAL : MAX_HEIGHT);

    // configuration (effective sizes)
    logic [SIZE_W-1:0]  width_reg,  width_next;
    logic [SIZE_W-1:0]  height_reg, height_next;
    border_mode_t       mode_reg,   mode_next;

    // input field split
    logic               in_func;
    logic signed [COORD_W-1:0] in_col;
    logic signed [COORD_W-1:0] in_row;
    logic [PIXEL_W-1:0] in_pix;
    coord_map_t         col_map;
    coord_map_t         row_map;
    logic               in_outside;
    logic               in_accept;
    logic               in_keep;

    // stage A: remapped coordinates
    logic               a_valid_reg;
    logic               a_write_reg;
    logic               a_outside_reg;
    logic               a_black_reg;
    logic [IDX_W-1:0]   a_col_reg;
    logic [IDX_W-1:0]   a_row_reg;
    logic [PIXEL_W-1:0] a_pix_reg;

    // stage B: memory read data
    logic               b_valid_reg;
    logic               b_outside_reg;
    logic               b_black_reg;

    // output register
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_pix_reg;
    logic               out_outside_reg;

    logic               out_free;
    logic               b_free;
    logic               a_move;
    logic               a_free;
    logic               mem_we;
    logic               mem_re;
    logic [PROD_W-1:0]  addr_full;
    logic [AW-1:0]      mem_addr;
    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] mem_rdata_reg;

    assign cfg_ready = 1'b1;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH: begin
                    width_next = (cfg_data == '0) ? SIZE_W'(1) :
                                 (cfg_data > W_LIMIT) ? W_LIMIT : cfg_data;
                end
                REG_IMAGE_HEIGHT: begin
                    height_next = (cfg_data == '0) ? SIZE_W'(1) :
                                  (cfg_data > H_LIMIT) ? H_LIMIT : cfg_data;
                end
                REG_BORDER_MODE: begin
                    mode_next = border_mode_t'(cfg_data[1:0]);
                end
                default: begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= (W_LIMIT < SIZE_W'(256)) ? W_LIMIT : SIZE_W'(256);
            height_reg <= (H_LIMIT < SIZE_W'(256)) ? H_LIMIT : SIZE_W'(256);
            mode_reg   <= BORDER_BLACK;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            mode_reg   <= mode_next;
        end
    end

    assign in_func = s_tuser[0];
    assign in_col  = $signed(s_tdata[9:0]);
    assign in_row  = $signed(s_tdata[19:10]);
    assign in_pix  = s_tdata[35:20];

    bep_coord_map u_col_map (
        .coord  (in_col),
        .size   (width_reg),
        .mode   (mode_reg),
        .result (col_map)
    );

    bep_coord_map u_row_map (
        .coord  (in_row),
        .size   (height_reg),
        .mode   (mode_reg),
        .result (row_map)
    );

    assign in_outside = col_map.outside || row_map.outside;
    // drop writes that fall outside the active area
    assign in_keep    = (in_func == FUNC_READ) || !in_outside;

    // pipeline flow control
    assign out_free  = !out_valid_reg || m_tready;
    assign b_free    = !b_valid_reg || out_free;
    assign a_move    = a_valid_reg && (a_write_reg || b_free);
    assign a_free    = !a_valid_reg || a_move;
    assign s_tready  = a_free;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= in_accept && in_keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            a_write_reg   <= (in_func == FUNC_WRITE);
            a_outside_reg <= in_outside;
            a_black_reg   <= in_outside && (mode_reg == BORDER_BLACK);
            a_col_reg     <= col_map.idx;
            a_row_reg     <= row_map.idx;
            a_pix_reg     <= in_pix;
        end
    end

    // column-major address as in the pixel layout
    assign addr_full = PROD_W'(a_col_reg) * PROD_W'(MAX_HEIGHT) + PROD_W'(a_row_reg);
    assign mem_addr  = addr_full[AW-1:0];
    assign mem_we    = a_move && a_write_reg;
    assign mem_re    = a_move && !a_write_reg && !a_black_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= a_pix_reg;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_free) begin
            b_valid_reg <= a_move && !a_write_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_free && a_move && !a_write_reg) begin
            b_outside_reg <= a_outside_reg;
            b_black_reg   <= a_black_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && b_valid_reg) begin
            out_pix_reg     <= b_black_reg ? '0 : mem_rdata_reg;
            out_outside_reg <= b_outside_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_pix_reg;
    assign m_tuser[0] = out_outside_reg;

    // single memory port: never a write and a read together
    `BEP_ASSERT_SAME(a_one_port, aclk, aresetn, mem_we, !mem_re)
    // a memory read lands in stage B
    `BEP_ASSERT_NEXT(a_read_lands, aclk, aresetn, mem_re, b_valid_reg && !b_black_reg)
    // read data held while stage B waits on the output register
    `BEP_ASSERT_NEXT(a_rdata_hold, aclk, aresetn, b_valid_reg && !out_free,
                     $stable(mem_rdata_reg) && b_valid_reg)
    // black border reads never touch the memory
    `BEP_ASSERT_SAME(a_black_no_read, aclk, aresetn, a_valid_reg && a_black_reg, !mem_re)

endmodule

[design/bep_coord_map.sv]
// ----------------------------------------------------------------------------
// bep_coord_map
// Maps one signed coordinate into [0, size-1] for the selected border mode.
// ----------------------------------------------------------------------------
module bep_coord_map (
    input  logic signed [bep_pkg::COORD_W-1:0] coord,
    input  logic        [bep_pkg::SIZE_W-1:0]  size,
    input  bep_pkg::border_mode_t              mode,
    output bep_pkg::coord_map_t                result
);
    import bep_pkg::*;

    localparam int EXT_W = 12;

    logic signed [EXT_W-1:0] c_ext;
    logic signed [EXT_W-1:0] s_ext;
    logic signed [EXT_W-1:0] mapped;
    logic signed [EXT_W-1:0] refl;
    logic                    below;
    logic                    above;

    assign c_ext = EXT_W'(coord);
    assign s_ext = $signed({{(EXT_W-SIZE_W){1'b0}}, size});
    assign below = c_ext < 0;
    assign above = c_ext >= s_ext;

    always_comb begin
        refl = above ? (s_ext + s_ext - EXT_W'(2) - c_ext) : c_ext;
        case (mode)
            BORDER_WRAP: begin
                if (below) begin
                    mapped = c_ext + s_ext;
                end else if (above) begin
                    mapped = c_ext - s_ext;
                end else begin
                    mapped = c_ext;
                end
            end
            BORDER_REFLECT: begin
                mapped = (refl < 0) ? -refl : refl;
            end
            default: begin
                mapped = c_ext;
            end
        endcase

        // final saturation to the active range
        if (mapped >= s_ext) begin
            result.idx = IDX_W'(s_ext - EXT_W'(1));
        end else if (mapped < 0) begin
            result.idx = '0;
        end else begin
            result.idx = IDX_W'(mapped);
        end
        result.outside = below || above;
    end

endmodule
